// File: rtl/tcgr_pkg.sv
// Shared types and constants for the text console glyph renderer.
package tcgr_pkg;

	localparam int GLYPH_COUNT_DEF = 256;
	localparam int QUEUE_DEPTH     = 2;

	localparam int ADDR_W  = 48;
	localparam int PITCH_W = 16;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 32;
	localparam int GLYPH_W = 64;
	localparam int CFG_W   = 48;
	localparam int REG_IDX_W = 3;

	localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0]  CURSOR_MAX   = 8'hFF;
	localparam logic [COLOR_W-1:0] FG_RESET     = 32'h00FF_FFFF;
	localparam logic [COLOR_W-1:0] BG_RESET     = 32'h0000_0000;

	localparam logic [REG_IDX_W-1:0] REG_FRAME_BASE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LINE_PITCH = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_TEXT_COLS  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_TEXT_ROWS  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FG_COLOR   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BG_COLOR   = 3'd5;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_PUT  = 1'b1
	} action_t;

	typedef struct packed {
		logic [GLYPH_W-1:0] glyph;
		logic [CHAR_W-1:0]  col;
		logic [CHAR_W-1:0]  line;
	} job_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  frame_base;
		logic [PITCH_W-1:0] line_pitch;
		logic [COLOR_W-1:0] fg_color;
		logic [COLOR_W-1:0] bg_color;
	} draw_cfg_t;

endpackage

// File: rtl/text_console_glyph_renderer_top.sv
// Top level: configuration registers, front end, job queue and pixel back end.
// A put that draws passes the front-end job register, the job queue, the back-end
// address stages and the character register; each drawn character then yields 64
// pixel writes, one per cycle while out_ready allows, out of the pixel output register.
// The two-entry job queue lets the front end keep accepting while pixels drain.
// Reset zeroes the cursor, loads register defaults and clears all pipeline valids.
module text_console_glyph_renderer_top #(
	parameter int GLYPH_COUNT = tcgr_pkg::GLYPH_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tcgr_pkg::REG_IDX_W-1:0]    cfg_idx,
	input  logic [tcgr_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              action,
	input  logic [tcgr_pkg::CHAR_W-1:0]       char_code,
	input  logic [tcgr_pkg::GLYPH_W-1:0]      glyph_bits,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tcgr_pkg::ADDR_W-1:0]       pixel_address,
	output logic [tcgr_pkg::COLOR_W-1:0]      pixel_value,
	output logic                              last_pixel
);
	import tcgr_pkg::*;

	draw_cfg_t         cfg_q;
	logic [CHAR_W-1:0] text_cols_q;
	logic [CHAR_W-1:0] text_rows_q;

	logic push;
	job_t push_job;
	logic queue_full;
	logic pop;
	job_t pop_job;
	logic queue_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_base <= '0;
			cfg_q.line_pitch <= '0;
			cfg_q.fg_color   <= FG_RESET;
			cfg_q.bg_color   <= BG_RESET;
			text_cols_q      <= '0;
			text_rows_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_FRAME_BASE: cfg_q.frame_base <= cfg_wdata[ADDR_W-1:0];
				REG_LINE_PITCH: cfg_q.line_pitch <= cfg_wdata[PITCH_W-1:0];
				REG_TEXT_COLS:  text_cols_q      <= cfg_wdata[CHAR_W-1:0];
				REG_TEXT_ROWS:  text_rows_q      <= cfg_wdata[CHAR_W-1:0];
				REG_FG_COLOR:   cfg_q.fg_color   <= cfg_wdata[COLOR_W-1:0];
				REG_BG_COLOR:   cfg_q.bg_color   <= cfg_wdata[COLOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tcgr_front #(
		.GLYPH_COUNT(GLYPH_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.char_code  (char_code),
		.glyph_bits (glyph_bits),
		.frame_base (cfg_q.frame_base),
		.text_cols  (text_cols_q),
		.text_rows  (text_rows_q),
		.push       (push),
		.push_job   (push_job),
		.queue_full (queue_full)
	);

	tcgr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (queue_full),
		.pop       (pop),
		.pop_job   (pop_job),
		.not_empty (queue_valid)
	);

	tcgr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.job_valid     (queue_valid),
		.job           (pop_job),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_address (pixel_address),
		.pixel_value   (pixel_value),
		.last_pixel    (last_pixel)
	);

endmodule

// File: rtl/tcgr_front.sv
// Front end: accepts words, loads the font store, tracks the cursor, issues draw jobs.
module tcgr_front #(
	parameter int GLYPH_COUNT = tcgr_pkg::GLYPH_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         action,
	input  logic [tcgr_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcgr_pkg::GLYPH_W-1:0] glyph_bits,
	input  logic [tcgr_pkg::ADDR_W-1:0]  frame_base,
	input  logic [tcgr_pkg::CHAR_W-1:0]  text_cols,
	input  logic [tcgr_pkg::CHAR_W-1:0]  text_rows,
	output logic                         push,
	output tcgr_pkg::job_t               push_job,
	input  logic                         queue_full
);
	import tcgr_pkg::*;

	localparam int IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

	logic [GLYPH_W-1:0] font_mem [GLYPH_COUNT];

	logic [CHAR_W-1:0]  col_q;
	logic [CHAR_W-1:0]  line_q;
	logic               valid_s1;
	logic               zero_s1;
	logic [CHAR_W-1:0]  col_s1;
	logic [CHAR_W-1:0]  line_s1;
	logic [GLYPH_W-1:0] glyph_s1;

	logic               acc;
	logic               is_load;
	logic               in_font;
	logic [IDX_W-1:0]   font_idx;
	logic               active;
	logic               is_nl;
	logic               wrap;
	logic [CHAR_W-1:0]  col_eff;
	logic [CHAR_W-1:0]  line_adv;
	logic [CHAR_W-1:0]  line_eff;
	logic               drop;
	logic               draw;

	assign in_ready = !valid_s1 || !queue_full;
	assign acc      = in_valid && in_ready;
	assign is_load  = action == ACT_LOAD;
	assign in_font  = {1'b0, char_code} < 9'(GLYPH_COUNT);
	assign font_idx = char_code[IDX_W-1:0];

	assign active   = acc && !is_load && (frame_base != '0) && (char_code != '0);
	assign is_nl    = char_code == NEWLINE_CODE;
	assign wrap     = col_q >= text_cols;
	assign col_eff  = wrap ? '0 : col_q;
	assign line_adv = (line_q < text_rows && line_q != CURSOR_MAX) ? line_q + 8'd1 : line_q;
	assign line_eff = wrap ? line_adv : line_q;
	assign drop     = line_eff >= text_rows;
	assign draw     = active && !is_nl && !drop && (col_eff < text_cols);

	assign push           = valid_s1 && !queue_full;
	assign push_job.glyph = zero_s1 ? '0 : glyph_s1;
	assign push_job.col   = col_s1;
	assign push_job.line  = line_s1;

	always_ff @(posedge clk) begin
		if (acc && is_load && in_font) begin
			font_mem[font_idx] <= glyph_bits;
		end
		if (draw) begin
			glyph_s1 <= font_mem[font_idx];
			zero_s1  <= !in_font;
			col_s1   <= col_eff;
			line_s1  <= line_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			line_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (draw) begin
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
			if (active) begin
				if (is_nl) begin
					col_q  <= '0;
					line_q <= line_adv;
				end else if (drop || col_eff == CURSOR_MAX) begin
					col_q  <= col_eff;
					line_q <= line_eff;
				end else begin
					col_q  <= col_eff + 8'd1;
					line_q <= line_eff;
				end
			end
		end
	end

	a_cursor_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		draw |=> valid_s1 && (line_s1 < text_rows) && (col_s1 < text_cols))
		else $error("draw job issued outside the text area");

	a_hold_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && queue_full |=> valid_s1 && $stable(col_s1) && $stable(line_s1))
		else $error("pending draw job lost while queue full");

	a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && queue_full |-> !acc)
		else $error("word accepted while draw job stalled");

endmodule

// File: rtl/tcgr_queue.sv
// Short job queue between the front end and the pixel back end.
module tcgr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tcgr_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output tcgr_pkg::job_t pop_job,
	output logic           not_empty
);
	import tcgr_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue underflow");

	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

// File: rtl/tcgr_back.sv
// Back end: turns draw jobs into 64 pixel writes, one per cycle while out_ready allows.
module tcgr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tcgr_pkg::draw_cfg_t           cfg,
	input  logic                          job_valid,
	input  tcgr_pkg::job_t                job,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tcgr_pkg::ADDR_W-1:0]   pixel_address,
	output logic [tcgr_pkg::COLOR_W-1:0]  pixel_value,
	output logic                          last_pixel
);
	import tcgr_pkg::*;

	localparam int PROD_W = CHAR_W + 3 + PITCH_W;

	logic               valid_s1;
	logic [GLYPH_W-1:0] glyph_s1;
	logic [CHAR_W-1:0]  col_s1;
	logic [PROD_W-1:0]  prod_s1;

	logic               valid_s2;
	logic [GLYPH_W-1:0] glyph_s2;
	logic [ADDR_W-1:0]  addr_s2;

	logic               busy_q;
	logic [5:0]         cnt_q;
	logic [GLYPH_W-1:0] glyph_q;
	logic [ADDR_W-1:0]  line_addr_q;

	logic               out_valid_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [COLOR_W-1:0] value_q;
	logic               last_q;

	logic ready_s1;
	logic ready_s2;
	logic emit;
	logic last_cnt;
	logic take;

	assign emit     = busy_q && (!out_valid_q || out_ready);
	assign last_cnt = cnt_q == 6'd63;
	assign take     = valid_s2 && (!busy_q || (emit && last_cnt));
	assign ready_s2 = !valid_s2 || take;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign pop      = job_valid && ready_s1;

	assign out_valid     = out_valid_q;
	assign pixel_address = addr_q;
	assign pixel_value   = value_q;
	assign last_pixel    = last_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			glyph_s1 <= job.glyph;
			col_s1   <= job.col;
			prod_s1  <= PROD_W'({job.line, 3'b000}) * PROD_W'(cfg.line_pitch);
		end
		if (valid_s1 && ready_s2) begin
			glyph_s2 <= glyph_s1;
			addr_s2  <= cfg.frame_base + ADDR_W'(prod_s1) + ADDR_W'({col_s1, 5'b00000});
		end
		if (take) begin
			glyph_q     <= glyph_s2;
			line_addr_q <= addr_s2;
		end else if (emit && cnt_q[2:0] == 3'd7) begin
			line_addr_q <= line_addr_q + ADDR_W'(cfg.line_pitch);
		end
		if (emit) begin
			addr_q  <= line_addr_q + ADDR_W'({cnt_q[2:0], 2'b00});
			value_q <= glyph_q[cnt_q] ? cfg.fg_color : cfg.bg_color;
			last_q  <= last_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (ready_s2) begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1 && ready_s2) begin
				valid_s2 <= 1'b1;
			end else if (take) begin
				valid_s2 <= 1'b0;
			end
			if (take) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (emit) begin
				cnt_q <= cnt_q + 6'd1;
				if (last_cnt) begin
					busy_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> cnt_q == '0)
		else $error("pixel counter running while idle");

	a_job_end: assert property (@(posedge clk) disable iff (!arst_n)
		emit && last_cnt |=> out_valid_q && last_q && (!busy_q || cnt_q == '0))
		else $error("character did not end on its last pixel");

	a_take_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !busy_q || (emit && last_cnt))
		else $error("new job overran a running character");

endmodule

// File: sim/text_console_glyph_renderer_top_tb.sv
// Self-checking testbench for the text console glyph renderer: predicts each pixel write.
module text_console_glyph_renderer_top_tb;
	import tcgr_pkg::*;

	localparam int STALL_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_WORDS   = 28;

	typedef struct {
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] value;
		logic               last;
	} pixel_write_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 in_valid;
	logic                 in_ready;
	logic                 action;
	logic [CHAR_W-1:0]    char_code;
	logic [GLYPH_W-1:0]   glyph_bits;
	logic                 out_valid;
	logic                 out_ready;
	logic [ADDR_W-1:0]    pixel_address;
	logic [COLOR_W-1:0]   pixel_value;
	logic                 last_pixel;

	// predictor state
	logic [GLYPH_W-1:0] glyph_font [GLYPH_COUNT_DEF];
	bit [GLYPH_COUNT_DEF-1:0] font_loaded;
	logic [CHAR_W-1:0]  loaded_codes [$];
	logic [CHAR_W-1:0]  cur_col;
	logic [CHAR_W-1:0]  cur_row;
	logic [ADDR_W-1:0]  reg_frame_base;
	logic [PITCH_W-1:0] reg_line_pitch;
	logic [CHAR_W-1:0]  reg_text_cols;
	logic [CHAR_W-1:0]  reg_text_rows;
	logic [COLOR_W-1:0] reg_fg_color;
	logic [COLOR_W-1:0] reg_bg_color;

	pixel_write_t pixel_q [$];
	pixel_write_t seen_px;
	int  fail_count;
	int  quiet_cycles;
	int  burst_left;
	bit  sender_steady;
	int  hold_request;
	int  rx_tick;
	int  rx_mode;

	text_console_glyph_renderer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.char_code    (char_code),
		.glyph_bits   (glyph_bits),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_address(pixel_address),
		.pixel_value  (pixel_value),
		.last_pixel   (last_pixel)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void next_text_row();
		cur_col = '0;
		if (cur_row < reg_text_rows && cur_row != CURSOR_MAX)
			cur_row++;
	endfunction

	function automatic void render_word(input action_t act, input logic [CHAR_W-1:0] code,
			input logic [GLYPH_W-1:0] glyph);
		logic [GLYPH_W-1:0] shape;
		logic [63:0] row_addr;
		pixel_write_t px;
		if (act == ACT_LOAD) begin
			glyph_font[code] = glyph;
			if (!font_loaded[code]) begin
				font_loaded[code] = 1'b1;
				loaded_codes.push_back(code);
			end
			return;
		end
		if (reg_frame_base == '0 || code == '0)
			return;
		if (code == NEWLINE_CODE) begin
			next_text_row();
			return;
		end
		if (cur_col >= reg_text_cols)
			next_text_row();
		if (cur_row >= reg_text_rows)
			return;
		if (cur_col < reg_text_cols) begin
			shape = glyph_font[code];
			for (int y = 0; y < 8; y++) begin
				row_addr = {16'h0, reg_frame_base} +
					({56'h0, cur_row} * 8 + y) * {48'h0, reg_line_pitch};
				for (int x = 0; x < 8; x++) begin
					px.addr  = ADDR_W'(row_addr + ({56'h0, cur_col} * 8 + x) * 4);
					px.value = shape[y * 8 + x] ? reg_fg_color : reg_bg_color;
					px.last  = (y == 7 && x == 7);
					pixel_q.push_back(px);
				end
			end
		end
		if (cur_col != CURSOR_MAX)
			cur_col++;
	endfunction

	task automatic send_word(input action_t act, input logic [CHAR_W-1:0] code,
			input logic [GLYPH_W-1:0] glyph);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = sender_steady ? 0 : $urandom_range(0, 9);
			if (gap != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid   <= 1'b1;
		action     <= act;
		char_code  <= code;
		glyph_bits <= glyph;
		do @(posedge clk); while (!in_ready);
		render_word(act, code, glyph);
	endtask

	task automatic put_loaded_char();
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		send_word(ACT_PUT, loaded_codes[$urandom_range(0, loaded_codes.size() - 1)], junk);
	endtask

	task automatic send_random_word();
		int pick;
		logic [63:0] junk;
		pick = $urandom_range(0, 99);
		junk = {$urandom, $urandom};
		if (pick < 15)
			send_word(ACT_LOAD, CHAR_W'($urandom_range(0, 255)), junk);
		else if (pick < 20)
			send_word(ACT_PUT, NEWLINE_CODE, junk);
		else if (pick < 23)
			send_word(ACT_PUT, '0, junk);
		else
			put_loaded_char();
	endtask

	// drop valid, drain all expected pixels, then let in-flight words retire
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FRAME_BASE: reg_frame_base = data[ADDR_W-1:0];
			REG_LINE_PITCH: reg_line_pitch = data[PITCH_W-1:0];
			REG_TEXT_COLS:  reg_text_cols  = data[CHAR_W-1:0];
			REG_TEXT_ROWS:  reg_text_rows  = data[CHAR_W-1:0];
			REG_FG_COLOR:   reg_fg_color   = data[COLOR_W-1:0];
			REG_BG_COLOR:   reg_bg_color   = data[COLOR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic test_font_load();
		send_word(ACT_LOAD, 8'h41, '1);
		send_word(ACT_LOAD, 8'h42, '0);
		send_word(ACT_LOAD, 8'hFF, 64'hAA55_F00F_0FF0_55AA);
		send_word(ACT_LOAD, 8'h80, 64'h8000_0000_0000_0001);
		send_word(ACT_LOAD, 8'h00, {$urandom, $urandom});
		send_word(ACT_LOAD, NEWLINE_CODE, {$urandom, $urandom});
	endtask

	task automatic test_drawing_disabled();
		send_word(ACT_PUT, 8'h41, '0);
		send_word(ACT_PUT, NEWLINE_CODE, '0);
		send_word(ACT_PUT, 8'hFF, '1);
		wait_idle();
	endtask

	task automatic test_wrap_and_row_limit();
		write_reg(REG_FRAME_BASE, 48'h0000_0000_1000);
		write_reg(REG_LINE_PITCH, 48'd2560);
		write_reg(REG_TEXT_COLS, 48'd3);
		write_reg(REG_TEXT_ROWS, 48'd2);
		send_word(ACT_PUT, 8'h41, '0);
		send_word(ACT_PUT, 8'h42, '0);
		send_word(ACT_PUT, 8'hFF, '0);
		send_word(ACT_PUT, 8'h80, '0);
		send_word(ACT_PUT, 8'h00, '0);
		send_word(ACT_PUT, NEWLINE_CODE, '0);
		send_word(ACT_PUT, 8'h41, '0);
		send_word(ACT_PUT, NEWLINE_CODE, '0);
		wait_idle();
	endtask

	task automatic test_register_extremes();
		write_reg(REG_FRAME_BASE, '1);
		write_reg(REG_LINE_PITCH, 48'hFFFF);
		write_reg(REG_TEXT_COLS, 48'd0);
		write_reg(REG_TEXT_ROWS, 48'd255);
		write_reg(REG_FG_COLOR, 48'h0);
		write_reg(REG_BG_COLOR, 48'hFFFF_FFFF);
		send_word(ACT_PUT, 8'h41, '0);
		wait_idle();
		write_reg(REG_TEXT_COLS, 48'd255);
		write_reg(REG_FG_COLOR, 48'hFFFF_FFFF);
		write_reg(REG_BG_COLOR, 48'h0);
		send_word(ACT_PUT, 8'hFF, '0);
		send_word(ACT_PUT, 8'h80, '0);
		wait_idle();
		write_reg(REG_TEXT_ROWS, 48'd0);
		send_word(ACT_PUT, 8'h41, '0);
		wait_idle();
	endtask

	// randomize all registers, usually opening one to three rows below the cursor so that most puts draw
	task automatic configure_random();
		logic [63:0] rnd;
		int rows;
		int pick;
		rnd = {$urandom, $urandom};
		pick = $urandom_range(0, 7);
		if (pick == 0)
			rnd[47:0] = '0;
		else if (pick == 1)
			rnd[47:32] = 16'hFFFF;
		write_reg(REG_FRAME_BASE, rnd[47:0]);
		rnd = {$urandom, $urandom};
		pick = $urandom_range(0, 7);
		if (pick == 0)
			rnd[15:0] = '0;
		else if (pick == 1)
			rnd[15:0] = '1;
		write_reg(REG_LINE_PITCH, rnd[47:0]);
		rnd = {$urandom, $urandom};
		pick = $urandom_range(0, 9);
		if (pick == 0)
			rnd[7:0] = '0;
		else if (pick == 1)
			rnd[7:0] = '1;
		else
			rnd[7:0] = CHAR_W'($urandom_range(1, 12));
		write_reg(REG_TEXT_COLS, rnd[47:0]);
		rows = cur_row + $urandom_range(1, 3);
		if ($urandom_range(0, 9) == 0)
			rows = $urandom_range(0, 255);
		if (rows > 255)
			rows = 255;
		rnd = {$urandom, $urandom};
		rnd[7:0] = CHAR_W'(rows);
		write_reg(REG_TEXT_ROWS, rnd[47:0]);
		rnd = {$urandom, $urandom};
		write_reg(REG_FG_COLOR, rnd[47:0]);
		rnd = {$urandom, $urandom};
		write_reg(REG_BG_COLOR, rnd[47:0]);
	endtask

	task automatic test_random_text();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			configure_random();
			sender_steady = ($urandom_range(0, 3) == 0);
			repeat (PHASE_WORDS) send_random_word();
			wait_idle();
		end
		sender_steady = 1'b0;
	endtask

	task automatic test_output_holdoff();
		write_reg(REG_FRAME_BASE, 48'h0000_0040_0000);
		write_reg(REG_TEXT_COLS, 48'd12);
		write_reg(REG_TEXT_ROWS, (cur_row > 252) ? 48'd255 : 48'(cur_row + 3));
		sender_steady = 1'b1;
		hold_request = HOLD_CYCLES;
		repeat (8) put_loaded_char();
		sender_steady = 1'b0;
		wait_idle();
	endtask

	task automatic test_sender_pause();
		repeat (5) put_loaded_char();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (5) put_loaded_char();
		wait_idle();
	endtask

	initial begin
		out_ready = 1'b0;
		rx_mode = 0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				out_ready <= 1'b0;
				repeat (hold_request) @(negedge clk);
				hold_request = 0;
			end
			rx_tick++;
			if (rx_tick % 97 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (rx_tick % 5) < 3;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pixel_q.size() == 0) begin
				$display("%0t: unexpected pixel write addr %h value %h last %b",
					$time, pixel_address, pixel_value, last_pixel);
				fail_count++;
			end else begin
				seen_px = pixel_q.pop_front();
				if (pixel_address !== seen_px.addr) begin
					$display("%0t: pixel_address expected %h actual %h",
						$time, seen_px.addr, pixel_address);
					fail_count++;
				end
				if (pixel_value !== seen_px.value) begin
					$display("%0t: pixel_value expected %h actual %h",
						$time, seen_px.value, pixel_value);
					fail_count++;
				end
				if (last_pixel !== seen_px.last) begin
					$display("%0t: last_pixel expected %b actual %b",
						$time, seen_px.last, last_pixel);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("text_console_glyph_renderer_top: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_idx    = '0;
		cfg_wdata  = '0;
		in_valid   = 1'b0;
		action     = ACT_LOAD;
		char_code  = '0;
		glyph_bits = '0;
		fail_count = 0;
		quiet_cycles = 0;
		burst_left = 0;
		sender_steady = 1'b0;
		hold_request = 0;
		rx_tick = 0;
		font_loaded = '0;
		cur_col = '0;
		cur_row = '0;
		reg_frame_base = '0;
		reg_line_pitch = '0;
		reg_text_cols  = '0;
		reg_text_rows  = '0;
		reg_fg_color   = FG_RESET;
		reg_bg_color   = BG_RESET;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_font_load();
		test_drawing_disabled();
		test_wrap_and_row_limit();
		test_register_extremes();
		test_output_holdoff();
		test_random_text();
		test_sender_pause();
		wait_idle();

		if (fail_count == 0)
			$display("text_console_glyph_renderer_top: match");
		else
			$display("text_console_glyph_renderer_top: mismatch");
		$finish;
	end

endmodule
